// ===== rtl/mtg_pkg.sv =====
// Package for the Mersenne Twister generator: word and index widths, generator constants,
// command codes and the twist and tempering helper functions.
// No dependencies; imported by mersenne_twister_generator_top.
`timescale 1ns / 1ps

package mtg_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned MT_DEPTH = 624;

    localparam logic [IDX_W-1:0] MT_N         = IDX_W'(MT_DEPTH);
    localparam logic [IDX_W-1:0] MT_M         = 10'd397;
    localparam logic [IDX_W-1:0] MT_WRAP      = MT_N - MT_M;
    localparam logic [IDX_W-1:0] MT_LAST      = MT_N - 10'd1;
    localparam logic [IDX_W-1:0] POS_UNSEEDED = MT_N + 10'd1;

    localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5690;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd5489;

    typedef enum logic [1:0] {
        CMD_EXTRACT = 2'd0,
        CMD_RESEED  = 2'd1,
        CMD_LOAD    = 2'd2
    } cmd_t;

    // Index of the next word, wrapping at the end of the state.
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == MT_LAST) ? '0 : p + 10'd1;
    endfunction

    // Index (p + M) mod N for p below N.
    function automatic logic [IDX_W-1:0] add_m(input logic [IDX_W-1:0] p);
        return (p < MT_WRAP) ? p + MT_M : p - MT_WRAP;
    endfunction

    // One twist step: upper bit of word i, lower bits of word i+1, mixed with word i+M.
    function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] w_i,
                                                     input logic [WORD_W-1:0] w_next,
                                                     input logic [WORD_W-1:0] w_m);
        logic [WORD_W-1:0] y;
        y = {w_i[WORD_W-1], w_next[WORD_W-2:0]};
        return w_m ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== rtl/mersenne_twister_generator_top.sv =====
// A new command is accepted only in the idle state, once the previous one has finished. An
// extract fetches the cached current word first when it is not valid (first extract after a
// reseed, load or full block), and its result waits until the output register is free.
// A reseed computes each word in a multiply step and an add step. A load while a block
// is partly consumed first finishes that block's twist at one word per cycle.
// Reset: the generator is unseeded and the seed register holds 5489; memory is not cleared.
`timescale 1ns / 1ps

module mersenne_twister_generator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // Command channel.
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic [mtg_pkg::IDX_W-1:0]   load_index,
    input  logic [mtg_pkg::WORD_W-1:0]  load_value,
    // Result channel.
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mtg_pkg::WORD_W-1:0]  random_value,
    output logic                        status,
    // Seed register write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mtg_pkg::WORD_W-1:0]  seed_value
);

    import mtg_pkg::*;

    // The state words live in one synchronous memory with two read ports and one write
    // port. The twist is done lazily: extracting word p computes the twisted value of
    // word p and writes it back in place. Because the in-place twist only ever looks
    // at already-twisted words below p and untwisted words above p, this gives exactly
    // the same sequence as twisting the whole block at once. The read position p means
    // words below p are twisted; position 624 means a new block must be started.
    //
    // Word p itself is kept in a cache register, loaded from the word p+1 read of the
    // previous step, so each step needs only two reads: word p+1 and word p+397.
    // A load while a block is half done must first finish twisting the remaining words,
    // since the loaded word joins a fully twisted block.

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_FETCH    = 7'b0000010,
        S_CALC     = 7'b0000100,
        S_LOAD     = 7'b0001000,
        S_RESP     = 7'b0010000,
        S_SEED_MUL = 7'b0100000,
        S_SEED_ADD = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] state_mem [MT_DEPTH];

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              rd_a_en, rd_b_en;
    logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;
    logic [WORD_W-1:0] rd_a_q, rd_b_q;

    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic              flush_reg, flush_next;
    logic [IDX_W-1:0]  ld_idx_reg, ld_idx_next;
    logic [WORD_W-1:0] ld_val_reg, ld_val_next;
    logic              res_status_reg, res_status_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [IDX_W-1:0]  seed_cnt_reg, seed_cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_value_reg, out_value_next;
    logic              out_status_reg, out_status_next;

    logic              in_fire, cfg_fire, out_free;
    logic              emit;
    logic [WORD_W-1:0] emit_value;
    logic              emit_status;
    logic              twist_start;
    logic [IDX_W-1:0]  start_p;
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] mul_lo;
    logic [WORD_W-1:0] seed_sum;
    cmd_t              cmd_in;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign random_value = out_value_reg;
    assign status       = out_status_reg;

    assign cmd_in   = cmd_t'(command);
    // A new block starts at word 0; otherwise continue at the read position.
    assign start_p  = (pos_reg == MT_N) ? '0 : pos_reg;
    assign new_word = twist_word(cur_reg, rd_a_q, rd_b_q);
    // Initialization recurrence: the multiply is registered, the index is added next cycle.
    assign mul_lo   = INIT_MULT * (x_reg ^ (x_reg >> 30));
    assign seed_sum = prod_reg + WORD_W'(seed_cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        p_next          = p_reg;
        cur_next        = cur_reg;
        cur_valid_next  = cur_valid_reg;
        flush_next      = flush_reg;
        ld_idx_next     = ld_idx_reg;
        ld_val_next     = ld_val_reg;
        res_status_next = res_status_reg;
        x_next          = x_reg;
        prod_next       = prod_reg;
        seed_cnt_next   = seed_cnt_reg;
        seed_next       = cfg_fire ? seed_value : seed_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        rd_a_en         = 1'b0;
        rd_b_en         = 1'b0;
        rd_a_addr       = '0;
        rd_b_addr       = '0;
        emit            = 1'b0;
        emit_value      = '0;
        emit_status     = 1'b0;
        twist_start     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ld_idx_next = load_index;
                    ld_val_next = load_value;
                    unique case (cmd_in)
                        CMD_EXTRACT:
                        begin
                            if (pos_reg > MT_N)
                            begin
                                res_status_next = 1'b1;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                flush_next  = 1'b0;
                                twist_start = 1'b1;
                            end
                        end
                        CMD_RESEED:
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = '0;
                            mem_wdata     = seed_reg;
                            x_next        = seed_reg;
                            seed_cnt_next = 10'd1;
                            state_next    = S_SEED_MUL;
                        end
                        CMD_LOAD:
                        begin
                            if (load_index >= MT_N)
                            begin
                                res_status_next = 1'b0;
                                state_next      = S_RESP;
                            end
                            else if (pos_reg < MT_N)
                            begin
                                // Finish the partly consumed block before the word goes in.
                                flush_next  = 1'b1;
                                twist_start = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        default:
                        begin
                            res_status_next = 1'b0;
                            state_next      = S_RESP;
                        end
                    endcase

                    if (twist_start)
                    begin
                        p_next    = start_p;
                        rd_b_en   = 1'b1;
                        rd_b_addr = add_m(start_p);
                        rd_a_en   = 1'b1;
                        if (cur_valid_reg)
                        begin
                            rd_a_addr  = wrap_inc(start_p);
                            state_next = S_CALC;
                        end
                        else
                        begin
                            rd_a_addr  = start_p;
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                cur_next   = rd_a_q;
                rd_a_en    = 1'b1;
                rd_a_addr  = wrap_inc(p_reg);
                state_next = S_CALC;
            end

            S_CALC:
            begin
                if (flush_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = p_reg;
                    mem_wdata = new_word;
                    pos_next  = p_reg + 10'd1;
                    if (p_reg == MT_LAST)
                    begin
                        cur_valid_next = 1'b0;
                        state_next     = S_LOAD;
                    end
                    else
                    begin
                        cur_next       = rd_a_q;
                        cur_valid_next = 1'b1;
                        p_next         = p_reg + 10'd1;
                        rd_a_en        = 1'b1;
                        rd_a_addr      = wrap_inc(p_reg + 10'd1);
                        rd_b_en        = 1'b1;
                        rd_b_addr      = add_m(p_reg + 10'd1);
                    end
                end
                else if (out_free)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = p_reg;
                    mem_wdata   = new_word;
                    pos_next    = p_reg + 10'd1;
                    emit        = 1'b1;
                    emit_value  = temper(new_word);
                    emit_status = 1'b0;
                    if (p_reg == MT_LAST)
                    begin
                        cur_valid_next = 1'b0;
                    end
                    else
                    begin
                        cur_next       = rd_a_q;
                        cur_valid_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_LOAD:
            begin
                if (out_free)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = ld_idx_reg;
                    mem_wdata      = ld_val_reg;
                    pos_next       = MT_N;
                    cur_valid_next = 1'b0;
                    emit           = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = res_status_reg;
                    state_next  = S_IDLE;
                end
            end

            S_SEED_MUL:
            begin
                prod_next  = mul_lo;
                state_next = S_SEED_ADD;
            end

            S_SEED_ADD:
            begin
                mem_we    = 1'b1;
                mem_waddr = seed_cnt_reg;
                mem_wdata = seed_sum;
                x_next    = seed_sum;
                if (seed_cnt_reg == MT_LAST)
                begin
                    pos_next        = MT_N;
                    cur_valid_next  = 1'b0;
                    res_status_next = 1'b0;
                    state_next      = S_RESP;
                end
                else
                begin
                    seed_cnt_next = seed_cnt_reg + 10'd1;
                    state_next    = S_SEED_MUL;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: holds one result item until it is taken.
    always_comb
    begin
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = emit_value;
            out_status_next = emit_status;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            state_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_a_en)
        begin
            rd_a_q <= state_mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_q <= state_mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= POS_UNSEEDED;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= SEED_DEFAULT;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            seed_reg      <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        cur_reg        <= cur_next;
        flush_reg      <= flush_next;
        ld_idx_reg     <= ld_idx_next;
        ld_val_reg     <= ld_val_next;
        res_status_reg <= res_status_next;
        x_reg          <= x_next;
        prod_reg       <= prod_next;
        seed_cnt_reg   <= seed_cnt_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTHESIS
    // The read position never leaves the range from zero up to the unseeded mark.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_UNSEEDED)
        else $error("read position out of range");

    // Every state memory write targets a real word.
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr < MT_N))
        else $error("state memory write beyond the last word");

    // A not-seeded status always comes with a zero value.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (random_value == '0))
        else $error("not-seeded result carries a nonzero value");

    // A result is only loaded while the output register is free to take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(random_value)))
        else $error("waiting result overwritten");
`endif

endmodule
